/* hdl/stts_pkg.sv */
// ----------------------------------------------------------------------------
// Token scanner package
// Shared widths, scan modes, token kinds and the token record type.
// ----------------------------------------------------------------------------
package stts_pkg;

    localparam int CntW   = 16;
    localparam int KwB    = 6;
    localparam int KindW  = 6;

    localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

    // scan modes, one-hot
    typedef enum logic [7:0] {
        M_IDLE     = 8'b0000_0001,
        M_OP       = 8'b0000_0010,
        M_COMMENT  = 8'b0000_0100,
        M_STRING   = 8'b0000_1000,
        M_NUMBER   = 8'b0001_0000,
        M_NUMDOT   = 8'b0010_0000,
        M_FRACTION = 8'b0100_0000,
        M_IDENT    = 8'b1000_0000
    } t_mode;

    localparam logic [KindW-1:0] K_STOP     = 6'd0;
    localparam logic [KindW-1:0] K_DOT      = 6'd7;
    localparam logic [KindW-1:0] K_OP_BASE  = 6'd9;
    localparam logic [KindW-1:0] K_STRING   = 6'd31;
    localparam logic [KindW-1:0] K_NUMBER   = 6'd32;
    localparam logic [KindW-1:0] K_IDENT    = 6'd33;
    localparam logic [KindW-1:0] K_KW_BASE  = 6'd34;
    localparam logic [KindW-1:0] K_ERR_CHAR = 6'd43;
    localparam logic [KindW-1:0] K_ERR_STR  = 6'd44;

    typedef struct packed {
        logic [KindW-1:0] kind;
        logic [CntW-1:0]  start;
        logic [CntW-1:0]  len;
        logic [CntW-1:0]  line;
    } t_tok;

    // up to three tokens for one byte, with a count
    typedef struct packed {
        logic [1:0] cnt;
        t_tok       t0;
        t_tok       t1;
        t_tok       t2;
    } t_group;

    function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] x);
        return (x == CntMax) ? x : x + 1'b1;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7a)) || ((b >= 8'h41) && (b <= 8'h5a));
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || ((b >= 8'd9) && (b <= 8'd13));
    endfunction

    // operator index 0..10, 4'hf if none
    function automatic logic [3:0] op_index(input logic [7:0] b);
        case (b)
            "+": return 4'd0;
            "-": return 4'd1;
            "*": return 4'd2;
            "/": return 4'd3;
            "%": return 4'd4;
            "<": return 4'd5;
            ">": return 4'd6;
            "=": return 4'd7;
            "!": return 4'd8;
            "&": return 4'd9;
            "|": return 4'd10;
            default: return 4'hf;
        endcase
    endfunction

    // punctuation kind 1..8, 0 if none
    function automatic logic [KindW-1:0] punct_kind(input logic [7:0] b);
        case (b)
            "(": return 6'd1;
            ")": return 6'd2;
            "{": return 6'd3;
            "}": return 6'd4;
            ";": return 6'd5;
            ",": return 6'd6;
            ".": return 6'd7;
            "^": return 6'd8;
            default: return 6'd0;
        endcase
    endfunction

endpackage

/* hdl/stts_front.sv */
// ----------------------------------------------------------------------------
// Token scanner front end
// Accepts one byte per cycle while the queue is not full, runs the scan mode
// machine and produces the group of tokens that the byte completes.
// ----------------------------------------------------------------------------
module stts_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_char,
    output logic              o_ready,
    output logic              o_push,
    output stts_pkg::t_group  o_group,
    input  logic              i_full
);
    import stts_pkg::*;

    t_mode           r_mode, n_mode;
    logic [7:0]      r_held, n_held;
    logic [CntW-1:0] r_begin, n_begin;
    logic [CntW-1:0] r_size, n_size;
    logic [CntW-1:0] r_line, n_line;
    logic [CntW-1:0] r_pos, n_pos;
    logic [7:0]      r_pref [KwB];
    logic            pref_we;
    logic [2:0]      pref_idx;

    logic            acc;
    t_group          grp;
    logic [3:0]      hk;
    logic            wordc;
    logic [KindW-1:0] wkind;
    logic [CntW-1:0] dot_start;
    logic [CntW:0]   dot_sum;

    assign o_ready = !i_full;
    assign acc     = i_valid && o_ready;

    // keyword match on the stored prefix
    always_comb begin
        wkind = K_IDENT;
        case (r_size)
            16'd2: begin
                if (r_pref[0] == "f" && r_pref[1] == "n") wkind = K_KW_BASE + 6'd2;
                if (r_pref[0] == "i" && r_pref[1] == "f") wkind = K_KW_BASE + 6'd4;
            end
            16'd3: begin
                if (r_pref[0] == "f" && r_pref[1] == "o" && r_pref[2] == "r")
                    wkind = K_KW_BASE + 6'd3;
                if (r_pref[0] == "v" && r_pref[1] == "a" && r_pref[2] == "r")
                    wkind = K_KW_BASE + 6'd7;
            end
            16'd4: begin
                if ({r_pref[0], r_pref[1], r_pref[2], r_pref[3]} == "else")
                    wkind = K_KW_BASE;
                if ({r_pref[0], r_pref[1], r_pref[2], r_pref[3]} == "true")
                    wkind = K_KW_BASE + 6'd6;
            end
            16'd5: begin
                if ({r_pref[0], r_pref[1], r_pref[2], r_pref[3], r_pref[4]} == "false")
                    wkind = K_KW_BASE + 6'd1;
                if ({r_pref[0], r_pref[1], r_pref[2], r_pref[3], r_pref[4]} == "while")
                    wkind = K_KW_BASE + 6'd8;
            end
            16'd6: begin
                if ({r_pref[0], r_pref[1], r_pref[2], r_pref[3], r_pref[4],
                     r_pref[5]} == "return")
                    wkind = K_KW_BASE + 6'd5;
            end
            default: wkind = K_IDENT;
        endcase
    end

    assign dot_sum   = {1'b0, r_begin} + {1'b0, r_size};
    assign dot_start = dot_sum[CntW] ? CntMax : dot_sum[CntW-1:0];
    assign wordc     = is_alpha(i_char) || is_digit(i_char) || (i_char == "_");

    // next state and token group
    always_comb begin
        t_tok tk;
        logic idle_go;
        logic [CntW-1:0] lnow;
        logic [KindW-1:0] pk;
        n_mode   = r_mode;
        n_held   = r_held;
        n_begin  = r_begin;
        n_size   = r_size;
        n_line   = r_line;
        n_pos    = sat_inc(r_pos);
        pref_we  = 1'b0;
        pref_idx = 3'd0;
        grp      = '0;
        idle_go  = 1'b0;
        hk       = op_index(r_held);
        if (hk == 4'hf) hk = 4'd0;
        tk.kind  = '0;
        tk.start = '0;
        tk.len   = '0;
        tk.line  = r_line;
        pk       = '0;
        lnow     = r_line;

        case (r_mode)
            M_OP: begin
                if (r_held == "/" && i_char == "/") begin
                    n_mode = M_COMMENT;
                end else if ((i_char == "=" && hk <= 4'd8) ||
                             (i_char == "&" && hk == 4'd9) ||
                             (i_char == "|" && hk == 4'd10)) begin
                    tk = '{K_OP_BASE + {1'b0, hk, 1'b0}, r_begin, 16'd2, r_line};
                    grp.t0 = tk; grp.cnt = 2'd1;
                    n_mode = M_IDLE;
                end else begin
                    tk = '{K_OP_BASE + {1'b0, hk, 1'b1}, r_begin, 16'd1, r_line};
                    grp.t0 = tk; grp.cnt = 2'd1;
                    idle_go = 1'b1;
                end
            end
            M_COMMENT: begin
                if (i_char == 8'd0 || i_char == 8'h0a) idle_go = 1'b1;
            end
            M_STRING: begin
                if (i_char == 8'd0) begin
                    grp.t0 = '{K_ERR_STR, r_begin, r_size, r_line}; grp.cnt = 2'd1;
                    idle_go = 1'b1;
                end else begin
                    n_size = sat_inc(r_size);
                    if (i_char == 8'h22) begin
                        grp.t0 = '{K_STRING, r_begin, sat_inc(r_size), r_line};
                        grp.cnt = 2'd1;
                        n_mode = M_IDLE;
                    end else if (i_char == 8'h0a) begin
                        n_line = sat_inc(r_line);
                    end
                end
            end
            M_NUMBER: begin
                if (is_digit(i_char)) n_size = sat_inc(r_size);
                else if (i_char == ".") n_mode = M_NUMDOT;
                else begin
                    grp.t0 = '{K_NUMBER, r_begin, r_size, r_line}; grp.cnt = 2'd1;
                    idle_go = 1'b1;
                end
            end
            M_NUMDOT: begin
                if (is_digit(i_char)) begin
                    n_size = sat_inc(sat_inc(r_size));
                    n_mode = M_FRACTION;
                end else begin
                    grp.t0 = '{K_NUMBER, r_begin, r_size, r_line};
                    grp.t1 = '{K_DOT, dot_start, 16'd1, r_line};
                    grp.cnt = 2'd2;
                    idle_go = 1'b1;
                end
            end
            M_FRACTION: begin
                if (is_digit(i_char)) n_size = sat_inc(r_size);
                else begin
                    grp.t0 = '{K_NUMBER, r_begin, r_size, r_line}; grp.cnt = 2'd1;
                    idle_go = 1'b1;
                end
            end
            M_IDENT: begin
                if (wordc) begin
                    if (r_size < 16'(KwB)) begin
                        pref_we  = 1'b1;
                        pref_idx = r_size[2:0];
                    end
                    n_size = sat_inc(r_size);
                end else begin
                    grp.t0 = '{wkind, r_begin, r_size, r_line}; grp.cnt = 2'd1;
                    idle_go = 1'b1;
                end
            end
            default: idle_go = 1'b1;
        endcase

        // byte handled between tokens
        if (idle_go) begin
            n_mode = M_IDLE;
            pk = punct_kind(i_char);
            tk = '{K_STOP, r_pos, 16'd1, lnow};
            if (i_char == 8'd0) begin
                tk.kind = K_STOP;
            end else if (is_space(i_char)) begin
                if (i_char == 8'h0a) n_line = sat_inc(r_line);
            end else if (pk != '0) begin
                tk.kind = pk;
            end else begin
                n_begin = r_pos;
                n_size  = 16'd1;
                if (op_index(i_char) != 4'hf) begin
                    n_mode = M_OP;
                    n_held = i_char;
                end else if (i_char == 8'h22) begin
                    n_mode = M_STRING;
                end else if (is_digit(i_char)) begin
                    n_mode = M_NUMBER;
                end else if (is_alpha(i_char) || i_char == "_") begin
                    n_mode   = M_IDENT;
                    pref_we  = 1'b1;
                    pref_idx = 3'd0;
                end else begin
                    tk.kind = K_ERR_CHAR;
                end
            end
            if (i_char == 8'd0 || (!is_space(i_char) && (pk != '0 ||
                (op_index(i_char) == 4'hf && i_char != 8'h22 && !is_digit(i_char)
                 && !is_alpha(i_char) && i_char != "_")))) begin
                case (grp.cnt)
                    2'd0:    grp.t0 = tk;
                    2'd1:    grp.t1 = tk;
                    default: grp.t2 = tk;
                endcase
                grp.cnt = grp.cnt + 2'd1;
            end
            if (i_char == 8'd0) begin
                n_mode  = M_IDLE;
                n_held  = 8'd0;
                n_begin = '0;
                n_size  = '0;
                n_line  = 16'd1;
                n_pos   = '0;
            end
        end
    end

    assign o_push  = acc && (grp.cnt != 2'd0);
    assign o_group = grp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_held  <= 8'd0;
            r_begin <= '0;
            r_size  <= '0;
            r_line  <= 16'd1;
            r_pos   <= '0;
        end else if (acc) begin
            r_mode  <= n_mode;
            r_held  <= n_held;
            r_begin <= n_begin;
            r_size  <= n_size;
            r_line  <= n_line;
            r_pos   <= n_pos;
        end
    end

    // identifier prefix, payload only
    always_ff @(posedge i_clk) begin
        if (acc && pref_we) r_pref[pref_idx] <= i_char;
    end

endmodule

/* hdl/stts_queue.sv */
// ----------------------------------------------------------------------------
// Token group queue
// Four-entry queue of token groups between front and back ends.
// ----------------------------------------------------------------------------
module stts_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  stts_pkg::t_group  i_group,
    output logic              o_full,
    output logic              o_valid,
    output stts_pkg::t_group  o_group,
    input  logic              i_pop
);
    import stts_pkg::*;

    t_group     r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       push, pop;

    assign o_full  = (r_cnt == 3'd4);
    assign o_valid = (r_cnt != 3'd0);
    assign o_group = r_mem[r_rp];
    assign push    = i_push && !o_full;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 2'd1;
            if (pop)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'b0, push} - {2'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_group;
    end

endmodule

/* hdl/stts_back.sv */
// ----------------------------------------------------------------------------
// Token scanner back end
// Serialises each token group onto the output stream, one token per
// transaction, through an output register.
// ----------------------------------------------------------------------------
module stts_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  stts_pkg::t_group  i_group,
    output logic              o_pop,
    output logic              o_tvalid,
    input  logic              i_tready,
    output stts_pkg::t_tok    o_tok,
    output logic              o_last
);
    import stts_pkg::*;

    logic [1:0] r_idx;
    logic       r_valid;
    t_tok       r_tok;
    logic       r_last;
    logic       load, lastn;
    t_tok       sel;

    always_comb begin
        case (r_idx)
            2'd0:    sel = i_group.t0;
            2'd1:    sel = i_group.t1;
            default: sel = i_group.t2;
        endcase
    end

    assign load  = i_valid && (!r_valid || i_tready);
    assign lastn = (r_idx + 2'd1 == i_group.cnt);
    assign o_pop = load && lastn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) r_idx <= lastn ? 2'd0 : r_idx + 2'd1;
            if (load) r_valid <= 1'b1;
            else if (i_tready) r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tok  <= sel;
            r_last <= lastn;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tok    = r_tok;
    assign o_last   = r_last;

endmodule

/* hdl/source_text_token_scanner.sv */
// ----------------------------------------------------------------------------
// Source text token scanner
// Streaming lexer: one ASCII byte in, zero to three tokens out.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis: one source byte per transaction in tdata; byte 0
//   ends the input, flushes pending tokens and emits a stop token.
//   Master channel m_axis: one token per transaction; tlast marks the last
//   token caused by one input byte.
//   Throughput: one byte per cycle while the queue is not full; a byte
//   yielding n tokens sends them one per transaction through the single output register.
//   Path: each byte's tokens pass the front end, then the four-entry group
//   queue, then the output register.
//   Reset clears the scan state, the queue and the output valid flag; the
//   block starts with line 1 and position 0, and returns to that after a
//   stop token.
//   A stall on m_axis fills the queue; s_axis_tready drops only once the
//   queue is full.
// ----------------------------------------------------------------------------
module source_text_token_scanner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [5:0] kind, [21:6] start, [37:22] length,
                                        // [53:38] line, rest zero
    output logic        m_axis_tlast
);
    import stts_pkg::*;

    logic   push, full, qvalid, pop;
    t_group fgrp, qgrp;
    t_tok   tok;

    stts_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_axis_tvalid),
        .i_char(s_axis_tdata), .o_ready(s_axis_tready), .o_push(push),
        .o_group(fgrp), .i_full(full)
    );

    stts_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_group(fgrp),
        .o_full(full), .o_valid(qvalid), .o_group(qgrp), .i_pop(pop)
    );

    stts_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(qvalid), .i_group(qgrp),
        .o_pop(pop), .o_tvalid(m_axis_tvalid), .i_tready(m_axis_tready),
        .o_tok(tok), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, tok.line, tok.len, tok.start, tok.kind};

    // no input taken while the queue is full
    a_no_acc_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !s_axis_tready) else $error("byte accepted with queue full");

    // a stop token is always the last of its group
    a_stop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && tok.kind == K_STOP) |-> m_axis_tlast)
        else $error("stop token not last");

    // a stalled token holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("output changed under stall");

endmodule
